// File: hw/rtl/pwma_pkg.sv
package pwma_pkg;

   // fixed field widths
   localparam int MASS_W  = 24;
   localparam int TH_W    = 40;
   localparam int GS_W    = 48;
   localparam int CNT_W   = 24;
   localparam int BOX_W   = 24;
   localparam int THR_W   = 48;
   localparam int GRS_W   = 44;
   localparam int SCALE_W = 32;
   localparam int RSP_W   = ((TH_W + GS_W + CNT_W + 7) / 8) * 8;

   // squared distance, saturating at 2^62
   localparam int R2_W = 63;
   localparam logic [R2_W-1:0] R2_SAT = {1'b1, 62'd0};

   // per item weight sum (27 images of at most 65535) and hit count
   localparam int WSUM_W  = 21;
   localparam int HIT_W   = 5;
   localparam int GPROD_W = MASS_W + WSUM_W;

   // table index starts at this bit of r2 * scale >> 16
   localparam int IDX_SHIFT = 24;

   // exp(-1/32) in q0.32, step of the weight table
   localparam logic [63:0] EXP_STEP_Q32 = 64'd4162825044;

   // image offset codes on one axis
   localparam logic [1:0] OFF_MINUS = 2'd0;
   localparam logic [1:0] OFF_ZERO  = 2'd1;
   localparam logic [1:0] OFF_PLUS  = 2'd2;

   // csr port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 48;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_LENGTH       = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOPHAT_RADIUS_SQ = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAUSS_RADIUS_SQ  = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_GAUSS_EXP_SCALE  = 4'd3;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ,
      ST_SQW,
      ST_PXY,
      ST_RZ,
      ST_TST,
      ST_MLO,
      ST_SUMS,
      ST_WACC,
      ST_GMUL,
      ST_TMUL,
      ST_UPD
   } state_type;

   function automatic logic [R2_W-1:0] add_r2(input logic [R2_W-1:0] a,
                                              input logic [R2_W-1:0] b);
      logic [R2_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      add_r2 = (s > {1'b0, R2_SAT}) ? R2_SAT : s[R2_W-1:0];
   endfunction

endpackage

// File: hw/rtl/pwma_mul.sv
module pwma_mul #(
   parameter int A_W = 48,
   parameter int B_W = 25
) (
   input  logic                 clock,
   input  logic [A_W-1:0]       mul_a,
   input  logic [B_W-1:0]       mul_b,
   output logic [A_W+B_W-1:0]   mul_prod
);

   logic [A_W+B_W-1:0] prod_in;
   logic [A_W+B_W-1:0] prod_ff;

   // product registered before anything else uses it
   assign prod_in = (A_W + B_W)'(mul_a) * (A_W + B_W)'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_prod = prod_ff;

endmodule

// File: hw/rtl/periodic_window_mass_accumulator_top.sv
// periodic window mass accumulator
// req channel: one source particle per item with the probe position and a flag
// that starts a new probe; rsp channel: one item of running totals per input
// item (top-hat mass, gaussian mass, top-hat image count).
// csr channel: register writes (box length, top-hat radius squared, gaussian
// radius squared, exponent scale), always ready; they are to be written only
// while idle, which the block itself does not enforce. the 27 periodic images
// of the source are walked one after another through a single shared
// multiplier: nine squared offsets first (ST_SQ, ST_SQW), then per image a
// partial-distance step (ST_PXY, ST_RZ), a window test (ST_TST) and, inside
// the window, two products for the table index and one table read (ST_MLO,
// ST_SUMS, ST_WACC); an x or xy group outside the gaussian window is pruned
// after ST_RZ. ST_GMUL, ST_TMUL and ST_UPD then give the final products and
// the update, which raises rsp_tvalid. an item is accepted only while the
// sequencer is idle, so a new item waits until the last has passed the update.
// the result sits in an output register, so the next item is taken while it
// waits; a stalled receiver only holds the block at the final update step.
// reset clears the sums and the control state and loads the register defaults
// (box length 8388608, the rest zero).
module periodic_window_mass_accumulator_top
   import pwma_pkg::*;
#(
   parameter int POS_BITS        = 24,
   parameter int EXP_TABLE_DEPTH = 256
) (
   input  logic                                           clock,
   input  logic                                           reset,
   // req_tdata: probe_x, probe_y, probe_z, src_x, src_y, src_z, src_mass, zero fill
   input  logic                                           req_tvalid,
   output logic                                           req_tready,
   input  logic [((6*POS_BITS+MASS_W+7)/8)*8-1:0]         req_tdata,
   // req_tuser: first
   input  logic                                           req_tuser,
   // rsp_tdata: tophat_mass, gauss_mass, tophat_count
   output logic                                           rsp_tvalid,
   input  logic                                           rsp_tready,
   output logic [RSP_W-1:0]                               rsp_tdata,
   input  logic                                           csr_valid,
   output logic                                           csr_ready,
   input  logic [CSR_IDX_W-1:0]                           csr_index,
   input  logic [CSR_DATA_W-1:0]                          csr_wdata
);

   localparam int BASE_W  = POS_BITS + 1;
   localparam int D_W     = POS_BITS + 2;
   localparam int MAG_W   = POS_BITS + 1;
   localparam int MUL_A_W = (MAG_W > 48) ? MAG_W : 48;
   localparam int MUL_B_W = (MAG_W > WSUM_W) ? MAG_W : WSUM_W;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int IDX_W   = $clog2(EXP_TABLE_DEPTH);
   localparam logic [1:0] LAST = 2'd2;

   typedef logic [15:0] rom_type [EXP_TABLE_DEPTH];

   // exp(-i/32) in q0.16, built at elaboration
   function automatic rom_type build_rom();
      rom_type     t;
      logic [63:0] v;
      logic [63:0] e;
      v = 64'd1 << 32;
      for (int n = 0; n < EXP_TABLE_DEPTH; n++) begin
         e    = (v + 64'h8000) >> 16;
         t[n] = (e > 64'hFFFF) ? 16'hFFFF : e[15:0];
         v    = ((v * EXP_STEP_Q32) + 64'h8000_0000) >> 32;
      end
      build_rom = t;
   endfunction

   localparam rom_type EXP_ROM = build_rom();

   // control
   state_type state_ff, state_in;

   // configuration
   logic [BOX_W-1:0]   box_ff,   box_in;
   logic [THR_W-1:0]   thr_ff,   thr_in;
   logic [GRS_W-1:0]   grs_ff,   grs_in;
   logic [SCALE_W-1:0] scale_ff, scale_in;

   // item
   logic signed [BASE_W-1:0] base_ff [3];
   logic signed [BASE_W-1:0] base_in [3];
   logic [MASS_W-1:0]        mass_ff, mass_in;

   // squared offsets per axis
   logic [R2_W-1:0] sqx_ff [3];
   logic [R2_W-1:0] sqx_in [3];
   logic [R2_W-1:0] sqy_ff [3];
   logic [R2_W-1:0] sqy_in [3];
   logic [R2_W-1:0] sqz_ff [3];
   logic [R2_W-1:0] sqz_in [3];

   logic [1:0] sq_ax_ff,  sq_ax_in;
   logic [1:0] sq_off_ff, sq_off_in;
   logic       wr_valid_ff, wr_valid_in;
   logic [1:0] wr_ax_ff,  wr_ax_in;
   logic [1:0] wr_off_ff, wr_off_in;
   logic       sat_ff,    sat_in;

   // image walk
   logic [1:0]      i_ff, i_in;
   logic [1:0]      j_ff, j_in;
   logic [1:0]      k_ff, k_in;
   logic [R2_W-1:0] pxy_ff, pxy_in;
   logic [R2_W-1:0] r2_ff,  r2_in;
   logic            prune_x_ff, prune_x_in;
   logic [63:0]     a_ff,   a_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic            idx_ok_ff, idx_ok_in;
   logic [WSUM_W-1:0] wsum_ff, wsum_in;
   logic [HIT_W-1:0]  hits_ff, hits_in;
   logic [GPROD_W-1:0] gprod_ff, gprod_in;

   // running sums and result register
   logic [TH_W-1:0]  tophat_ff, tophat_in;
   logic [GS_W-1:0]  gauss_ff,  gauss_in;
   logic [CNT_W-1:0] count_ff,  count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0] rsp_data_ff,  rsp_data_in;

   // shared multiplier
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [PROD_W-1:0]  prod;

   // combinational helpers
   logic                    accept;
   logic                    out_free;
   logic [R2_W-1:0]         gcut;
   logic signed [BASE_W-1:0] base_sel;
   logic signed [D_W-1:0]   off_val;
   logic signed [D_W-1:0]   d_val;
   logic [MAG_W-1:0]        mag;
   logic                    mag_sat;
   logic [R2_W-1:0]         sq_val;
   logic                    in_gauss;
   logic                    pxy_out;
   logic [64:0]             idx_sum;
   logic [15:0]             rom_w;
   logic [TH_W:0]           th_sum;
   logic [GS_W:0]           gs_sum;
   logic [CNT_W:0]          cnt_sum;

   // walk advance
   logic [1:0] adv_i, adv_j, adv_k;
   logic       adv_done;
   logic [1:0] ai_i, aj_i, aj_j;
   logic       ai_done, aj_done;

   pwma_mul #(
      .A_W (MUL_A_W),
      .B_W (MUL_B_W)
   ) u_mul (
      .clock    (clock),
      .mul_a    (mul_a),
      .mul_b    (mul_b),
      .mul_prod (prod)
   );

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // window cut is sixteen times the gaussian radius squared
   assign gcut     = R2_W'({grs_ff, 4'b0000});
   assign in_gauss = r2_ff < gcut;
   assign pxy_out  = pxy_ff >= gcut;

   // one signed offset per cycle while the squares are built
   always_comb begin
      base_sel = base_ff[sq_ax_ff];
      case (sq_off_ff)
         OFF_MINUS: off_val = -D_W'({1'b0, POS_BITS'(box_ff)});
         OFF_PLUS:  off_val =  D_W'({1'b0, POS_BITS'(box_ff)});
         default:   off_val = '0;
      endcase
      d_val   = D_W'(base_sel) + off_val;
      mag     = d_val[D_W-1] ? MAG_W'(-d_val) : MAG_W'(d_val);
      mag_sat = 64'(mag) > 64'h7FFF_FFFF;
   end

   assign sq_val  = sat_ff ? R2_SAT : R2_W'(prod[61:0]);
   assign idx_sum = 65'(a_ff) + 65'(prod[63:16]);
   assign rom_w   = EXP_ROM[idx_ff];
   assign th_sum  = {1'b0, tophat_ff} + (TH_W + 1)'(prod[MASS_W+HIT_W-1:0]);
   assign gs_sum  = {1'b0, gauss_ff} + (GS_W + 1)'(gprod_ff);
   assign cnt_sum = {1'b0, count_ff} + (CNT_W + 1)'(hits_ff);

   // next image: outer step, middle step, innermost step
   always_comb begin
      ai_i    = (i_ff == LAST) ? i_ff : i_ff + 2'd1;
      ai_done = (i_ff == LAST);
      aj_i    = (j_ff == LAST) ? ai_i : i_ff;
      aj_j    = (j_ff == LAST) ? 2'd0 : j_ff + 2'd1;
      aj_done = (j_ff == LAST) && ai_done;
      if (state_ff == ST_RZ && prune_x_ff) begin
         adv_i    = ai_i;
         adv_j    = 2'd0;
         adv_k    = 2'd0;
         adv_done = ai_done;
      end else if (state_ff == ST_RZ) begin
         adv_i    = aj_i;
         adv_j    = aj_j;
         adv_k    = 2'd0;
         adv_done = aj_done;
      end else if (k_ff != LAST) begin
         adv_i    = i_ff;
         adv_j    = j_ff;
         adv_k    = k_ff + 2'd1;
         adv_done = 1'b0;
      end else begin
         adv_i    = aj_i;
         adv_j    = aj_j;
         adv_k    = 2'd0;
         adv_done = aj_done;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_SQ;
         ST_SQ:   if (sq_ax_ff == LAST && sq_off_ff == LAST) state_in = ST_SQW;
         ST_SQW:  state_in = ST_PXY;
         ST_PXY:  state_in = ST_RZ;
         ST_RZ: begin
            if (prune_x_ff || pxy_out) begin
               state_in = adv_done ? ST_GMUL : ST_PXY;
            end else begin
               state_in = ST_TST;
            end
         end
         ST_TST: begin
            if (in_gauss) begin
               state_in = ST_MLO;
            end else begin
               state_in = adv_done ? ST_GMUL : ST_PXY;
            end
         end
         ST_MLO:  state_in = ST_SUMS;
         ST_SUMS: state_in = ST_WACC;
         ST_WACC: state_in = adv_done ? ST_GMUL : ST_PXY;
         ST_GMUL: state_in = ST_TMUL;
         ST_TMUL: state_in = ST_UPD;
         ST_UPD:  if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs: handshake and multiplier operands
   always_comb begin
      req_tready = 1'b0;
      mul_a      = '0;
      mul_b      = '0;
      case (state_ff)
         ST_IDLE: req_tready = 1'b1;
         ST_SQ: begin
            mul_a = MUL_A_W'(mag);
            mul_b = MUL_B_W'(mag);
         end
         ST_TST: begin
            mul_a = MUL_A_W'(r2_ff[47:0]);
            mul_b = MUL_B_W'(scale_ff[31:16]);
         end
         ST_MLO: begin
            mul_a = MUL_A_W'(r2_ff[47:0]);
            mul_b = MUL_B_W'(scale_ff[15:0]);
         end
         ST_GMUL: begin
            mul_a = MUL_A_W'(mass_ff);
            mul_b = MUL_B_W'(wsum_ff);
         end
         ST_TMUL, ST_UPD: begin
            mul_a = MUL_A_W'(mass_ff);
            mul_b = MUL_B_W'(hits_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // datapath next values
   always_comb begin
      box_in       = box_ff;
      thr_in       = thr_ff;
      grs_in       = grs_ff;
      scale_in     = scale_ff;
      base_in      = base_ff;
      mass_in      = mass_ff;
      sqx_in       = sqx_ff;
      sqy_in       = sqy_ff;
      sqz_in       = sqz_ff;
      sq_ax_in     = sq_ax_ff;
      sq_off_in    = sq_off_ff;
      wr_valid_in  = 1'b0;
      wr_ax_in     = wr_ax_ff;
      wr_off_in    = wr_off_ff;
      sat_in       = sat_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      pxy_in       = pxy_ff;
      r2_in        = r2_ff;
      prune_x_in   = prune_x_ff;
      a_in         = a_ff;
      idx_in       = idx_ff;
      idx_ok_in    = idx_ok_ff;
      wsum_in      = wsum_ff;
      hits_in      = hits_ff;
      gprod_in     = gprod_ff;
      tophat_in    = tophat_ff;
      gauss_in     = gauss_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid) begin
         case (csr_index)
            CSR_BOX_LENGTH:       box_in   = csr_wdata[BOX_W-1:0];
            CSR_TOPHAT_RADIUS_SQ: thr_in   = csr_wdata[THR_W-1:0];
            CSR_GAUSS_RADIUS_SQ:  grs_in   = csr_wdata[GRS_W-1:0];
            CSR_GAUSS_EXP_SCALE:  scale_in = csr_wdata[SCALE_W-1:0];
            default: ;
         endcase
      end

      // square is written from the registered product, with its axis and offset held in wr_ax_ff and wr_off_ff
      if (wr_valid_ff) begin
         case (wr_ax_ff)
            2'd0:    sqx_in[wr_off_ff] = sq_val;
            2'd1:    sqy_in[wr_off_ff] = sq_val;
            default: sqz_in[wr_off_ff] = sq_val;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               for (int a = 0; a < 3; a++) begin
                  base_in[a] = $signed({1'b0, req_tdata[a*POS_BITS +: POS_BITS]})
                             - $signed({1'b0, req_tdata[(a+3)*POS_BITS +: POS_BITS]});
               end
               mass_in   = req_tdata[6*POS_BITS +: MASS_W];
               sq_ax_in  = 2'd0;
               sq_off_in = 2'd0;
               i_in      = 2'd0;
               j_in      = 2'd0;
               k_in      = 2'd0;
               wsum_in   = '0;
               hits_in   = '0;
               if (req_tuser) begin
                  tophat_in = '0;
                  gauss_in  = '0;
                  count_in  = '0;
               end
            end
         end
         ST_SQ: begin
            wr_valid_in = 1'b1;
            wr_ax_in    = sq_ax_ff;
            wr_off_in   = sq_off_ff;
            sat_in      = mag_sat;
            if (sq_off_ff == LAST) begin
               sq_off_in = 2'd0;
               sq_ax_in  = sq_ax_ff + 2'd1;
            end else begin
               sq_off_in = sq_off_ff + 2'd1;
            end
         end
         ST_PXY: begin
            pxy_in     = add_r2(sqx_ff[i_ff], sqy_ff[j_ff]);
            prune_x_in = sqx_ff[i_ff] >= gcut;
         end
         ST_RZ: begin
            r2_in = add_r2(pxy_ff, sqz_ff[k_ff]);
            if (prune_x_ff || pxy_out) begin
               i_in = adv_i;
               j_in = adv_j;
               k_in = adv_k;
            end
         end
         ST_TST: begin
            if (r2_ff < R2_W'(thr_ff)) hits_in = hits_ff + HIT_W'(1);
            if (!in_gauss) begin
               i_in = adv_i;
               j_in = adv_j;
               k_in = adv_k;
            end
         end
         ST_MLO:  a_in = prod[63:0];
         ST_SUMS: begin
            idx_in    = idx_sum[IDX_SHIFT +: IDX_W];
            idx_ok_in = idx_sum[64:IDX_SHIFT] < (65 - IDX_SHIFT)'(EXP_TABLE_DEPTH);
         end
         ST_WACC: begin
            wsum_in = wsum_ff + (idx_ok_ff ? WSUM_W'(rom_w) : WSUM_W'(0));
            i_in    = adv_i;
            j_in    = adv_j;
            k_in    = adv_k;
         end
         ST_TMUL: gprod_in = prod[GPROD_W-1:0];
         ST_UPD: begin
            if (out_free) begin
               tophat_in    = th_sum[TH_W] ? {TH_W{1'b1}} : th_sum[TH_W-1:0];
               gauss_in     = gs_sum[GS_W] ? {GS_W{1'b1}} : gs_sum[GS_W-1:0];
               count_in     = cnt_sum[CNT_W] ? {CNT_W{1'b1}} : cnt_sum[CNT_W-1:0];
               rsp_data_in  = RSP_W'({count_in, gauss_in, tophat_in});
               rsp_valid_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   // control registers and sums
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         box_ff       <= BOX_W'(8388608);
         thr_ff       <= '0;
         grs_ff       <= '0;
         scale_ff     <= '0;
         tophat_ff    <= '0;
         gauss_ff     <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         wr_valid_ff  <= wr_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         box_ff       <= box_in;
         thr_ff       <= thr_in;
         grs_ff       <= grs_in;
         scale_ff     <= scale_in;
         tophat_ff    <= tophat_in;
         gauss_ff     <= gauss_in;
         count_ff     <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      base_ff     <= base_in;
      mass_ff     <= mass_in;
      sqx_ff      <= sqx_in;
      sqy_ff      <= sqy_in;
      sqz_ff      <= sqz_in;
      sq_ax_ff    <= sq_ax_in;
      sq_off_ff   <= sq_off_in;
      wr_ax_ff    <= wr_ax_in;
      wr_off_ff   <= wr_off_in;
      sat_ff      <= sat_in;
      i_ff        <= i_in;
      j_ff        <= j_in;
      k_ff        <= k_in;
      pxy_ff      <= pxy_in;
      r2_ff       <= r2_in;
      prune_x_ff  <= prune_x_in;
      a_ff        <= a_in;
      idx_ff      <= idx_in;
      idx_ok_ff   <= idx_ok_in;
      wsum_ff     <= wsum_in;
      hits_ff     <= hits_in;
      gprod_ff    <= gprod_in;
      rsp_data_ff <= rsp_data_in;
   end

   // a new item always starts the square pass with empty per-item totals
   a_accept_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_SQ) && (hits_ff == '0) && (wsum_ff == '0))
      else $error("item did not start the square pass cleanly");

   // no more hits than periodic images
   a_hits_bound: assert property (@(posedge clock) disable iff (reset)
      hits_ff <= HIT_W'(27))
      else $error("hit count beyond image count");

   // square writes only come from the square pass
   a_sq_write: assert property (@(posedge clock) disable iff (reset)
      wr_valid_ff |-> (state_ff == ST_SQ || state_ff == ST_SQW))
      else $error("square write outside the square pass");

   // the final update always shows a result in the next cycle
   a_upd_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPD && out_free) |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("update did not present a result");

endmodule
